### sv/tscw_pkg.sv
// Shared types and constants for the terminal screen character writer.
// Depends on nothing; used by the screen memory and the top level.
package tscw_pkg;

    // Default screen geometry
    localparam int DEFAULT_COLUMNS = 40;
    localparam int DEFAULT_ROWS    = 24;

    // Width of one stored character cell
    localparam int CHAR_W = 7;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_CR         = 7'h0D;
    localparam logic [CHAR_W-1:0] CODE_BS         = 7'h08;
    localparam logic [CHAR_W-1:0] CODE_RUBOUT     = 7'h7F;
    localparam logic [CHAR_W-1:0] CODE_UNDERSCORE = 7'h5F;
    localparam logic [CHAR_W-1:0] CODE_SPACE      = 7'h20;
    localparam logic [CHAR_W-1:0] CODE_LOWER_A    = 7'h61;
    localparam logic [CHAR_W-1:0] CODE_LOWER_Z    = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET     = 7'h20;

    // Input transaction
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_in;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [4:0]        cursor_row;
        logic [5:0]        cursor_col;
        logic              scrolled;
        logic [CHAR_W-1:0] read_char;
    } result_t;

endpackage

### sv/tscw_screen_ram.sv
// Screen cell memory: one write port and one registered read port.
// Depends on tscw_pkg for the cell width.
module tscw_screen_ram #(
    parameter int DEPTH = tscw_pkg::DEFAULT_ROWS * tscw_pkg::DEFAULT_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tscw_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tscw_pkg::CHAR_W-1:0] rd_data
);

    logic [tscw_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tscw_pkg::CHAR_W-1:0] rd_data_reg;

    // Write one cell
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one cell into the output register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/terminal_screen_char_writer.sv
// Top level of the terminal screen character writer: sequencer, cursor and result register.
// Depends on tscw_pkg and tscw_screen_ram.
//
// Keeps a ROWS by COLUMNS screen of 7-bit codes and a cursor. A transaction is taken when
// start is high and busy is low; its result appears on result for exactly one cycle with
// done high, and the receiver cannot stall it, so capture it on that cycle. A write that
// does not scroll, a mode 3 item and an out-of-range read give their result in the cycle
// after acceptance; an in-range read first passes the read state (registered memory read).
// A clear fills every cell, and a write that scrolls runs the scroll copy and then fills
// the bottom row: one shared address counter walks the screen memory one cell per cycle
// through its single write port. After reset the block runs a clearing pass over every
// cell with busy high before it takes its first transaction.
module terminal_screen_char_writer #(
    parameter int COLUMNS = tscw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tscw_pkg::DEFAULT_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tscw_pkg::item_t   item,
    output logic              done,
    output tscw_pkg::result_t result
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int LAST  = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;

    logic [2:0]                  state_reg, state_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [AW-1:0]               scan_reg, scan_next;
    logic                        cp_valid_reg, cp_valid_next;
    logic [AW-1:0]               cp_addr_reg, cp_addr_next;
    logic                        silent_reg, silent_next;
    logic                        done_reg, done_next;
    logic                        scr_reg, scr_next;
    logic [tscw_pkg::CHAR_W-1:0] rch_reg, rch_next;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tscw_pkg::CHAR_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [tscw_pkg::CHAR_W-1:0] rd_data;

    logic                        accept;
    logic [tscw_pkg::CHAR_W-1:0] code;
    logic [tscw_pkg::CHAR_W-1:0] upper_code;
    logic                        is_cr;
    logic                        is_bs;
    logic                        is_print;
    logic                        col_last;
    logic                        row_last;
    logic                        read_ok;
    logic [AW-1:0]               cur_addr;
    logic [AW-1:0]               read_addr;

    tscw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the incoming transaction
    assign accept   = start && !busy;
    assign code     = item.char_in[tscw_pkg::CHAR_W-1:0];
    assign is_cr    = (code == tscw_pkg::CODE_CR);
    assign is_bs    = (code == tscw_pkg::CODE_BS) || (code == tscw_pkg::CODE_RUBOUT)
                   || (code == tscw_pkg::CODE_UNDERSCORE);
    assign is_print = !is_bs && (code >= tscw_pkg::CODE_SPACE);
    assign upper_code = ((code >= tscw_pkg::CODE_LOWER_A) && (code <= tscw_pkg::CODE_LOWER_Z))
                      ? (code - tscw_pkg::CASE_OFFSET) : code;
    assign col_last = (col_reg == CW'(COLUMNS - 1));
    assign row_last = (row_reg == RW'(ROWS - 1));
    assign read_ok  = (32'(item.read_row) < ROWS) && (32'(item.read_col) < COLUMNS);
    assign cur_addr = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign read_addr = AW'(32'(item.read_row) * COLUMNS + 32'(item.read_col));

    // Sequence cursor moves, reads, the scroll copy and fills
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scan_next     = scan_reg;
        cp_valid_next = 1'b0;
        cp_addr_next  = cp_addr_reg;
        silent_next   = silent_reg;
        done_next     = 1'b0;
        scr_next      = scr_reg;
        rch_next      = rch_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_addr;
        wr_data       = tscw_pkg::CODE_SPACE;
        rd_en         = 1'b0;
        rd_addr       = read_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scr_next = 1'b0;
                    rch_next = '0;
                    done_next = 1'b1;
                    unique case (item.mode)
                        tscw_pkg::MODE_WRITE:
                        begin
                            if (is_cr || (is_print && col_last))
                            begin
                                col_next = '0;
                                if (row_last)
                                begin
                                    // Start the scroll copy; result comes after the fill
                                    state_next = ST_SCROLL;
                                    scan_next  = '0;
                                    scr_next   = 1'b1;
                                    done_next  = 1'b0;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                end
                            end
                            else if (is_print)
                            begin
                                col_next = col_reg + CW'(1);
                            end
                            else if (is_bs && (col_reg != '0))
                            begin
                                col_next = col_reg - CW'(1);
                            end

                            if (is_print)
                            begin
                                wr_en   = 1'b1;
                                wr_data = upper_code;
                            end
                            else if (is_bs && (col_reg != '0))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_addr - AW'(1);
                            end
                        end
                        tscw_pkg::MODE_READ:
                        begin
                            if (read_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                                done_next  = 1'b0;
                            end
                        end
                        tscw_pkg::MODE_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            scan_next  = '0;
                            state_next = ST_FILL;
                            done_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rch_next   = rd_data;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // Write back the cell read last cycle one row up
                wr_en   = cp_valid_reg;
                wr_addr = cp_addr_reg;
                wr_data = rd_data;
                if (scan_reg == AW'(LAST))
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg + AW'(COLUMNS);
                    cp_valid_next = 1'b1;
                    cp_addr_next  = scan_reg;
                    scan_next     = scan_reg + AW'(1);
                end
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = scan_reg;
                if (scan_reg == AW'(CELLS - 1))
                begin
                    state_next  = ST_IDLE;
                    done_next   = !silent_reg;
                    silent_next = 1'b0;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            row_reg      <= '0;
            col_reg      <= '0;
            scan_reg     <= '0;
            cp_valid_reg <= 1'b0;
            silent_reg   <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            scan_reg     <= scan_next;
            cp_valid_reg <= cp_valid_next;
            silent_reg   <= silent_next;
            done_reg     <= done_next;
        end
    end

    // Hold payload of the copy pipe and the result
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
        scr_reg     <= scr_next;
        rch_reg     <= rch_next;
    end

    // Drive the ports
    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign result.cursor_row = 5'(32'(row_reg));
    assign result.cursor_col = 6'(32'(col_reg));
    assign result.scrolled   = scr_reg;
    assign result.read_char  = rch_reg;

    // A result is only shown while the block is ready for the next transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    // A clear transaction always makes the block busy
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == tscw_pkg::MODE_CLEAR)) |=> (busy && !done_reg))
        else $error("clear did not start a fill");

    // The cursor column stays on the screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column off screen");

    // A pending copy write exists only during the scroll
    a_copy_scope: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> (state_reg == ST_SCROLL))
        else $error("copy write outside scroll");

    // The reset clearing pass gives no result
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        silent_reg |-> !done_reg)
        else $error("result during reset clearing pass");

endmodule

### bench/terminal_screen_char_writer_tb.sv
// Self-checking testbench for terminal_screen_char_writer: directed and random transactions
// against an in-bench screen predictor. Depends on tscw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module terminal_screen_char_writer_tb;
    import tscw_pkg::*;

    localparam int COLS           = DEFAULT_COLUMNS;
    localparam int LINES          = DEFAULT_ROWS;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 580;
    localparam int GAP_FREE_TAIL  = 100;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int MAX_REPORTS    = 10;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Predicted screen contents and cursor
    logic [CHAR_W-1:0] screen_mem [LINES][COLS];
    int cur_r;
    int cur_c;

    // Results expected from accepted transactions, oldest first
    result_t expected_q[$];
    result_t want_res;

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  useful_items   = 0;
    int  results_seen   = 0;
    int  scrolls_seen   = 0;
    int  reads_sent     = 0;
    int  clears_sent    = 0;
    bit  gaps_on        = 1'b1;

    terminal_screen_char_writer #(
        .COLUMNS(COLS),
        .ROWS   (LINES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .done  (done),
        .result(result)
    );

    always #4 clk = ~clk;

    // Fill the predicted screen with spaces
    function automatic void blank_screen_model();
        for (int r = 0; r < LINES; r++)
            for (int c = 0; c < COLS; c++)
                screen_mem[r][c] = CODE_SPACE;
    endfunction

    // Move to column 0 of the next line; scroll at the bottom. Returns 1 on scroll.
    function automatic logic line_feed_model();
        cur_c = 0;
        cur_r++;
        if (cur_r >= LINES)
        begin
            for (int r = 0; r < LINES - 1; r++)
                for (int c = 0; c < COLS; c++)
                    screen_mem[r][c] = screen_mem[r + 1][c];
            for (int c = 0; c < COLS; c++)
                screen_mem[LINES - 1][c] = CODE_SPACE;
            cur_r = LINES - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one transaction to the predicted screen and return its result
    function automatic result_t predict_screen(item_t it);
        logic [CHAR_W-1:0] code;
        logic              rolled;
        result_t           r;
        code   = it.char_in[CHAR_W-1:0];
        rolled = 1'b0;
        r      = '0;
        case (it.mode)
            MODE_WRITE:
            begin
                if (code == CODE_CR)
                    rolled = line_feed_model();
                else if (code == CODE_BS || code == CODE_RUBOUT || code == CODE_UNDERSCORE)
                begin
                    if (cur_c > 0)
                    begin
                        cur_c--;
                        screen_mem[cur_r][cur_c] = CODE_SPACE;
                    end
                end
                else if (code >= CODE_SPACE)
                begin
                    if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z)
                        code = code - CASE_OFFSET;
                    screen_mem[cur_r][cur_c] = code;
                    cur_c++;
                    if (cur_c >= COLS)
                        rolled = line_feed_model();
                end
            end
            MODE_READ:
            begin
                if (it.read_row < LINES && it.read_col < COLS)
                    r.read_char = screen_mem[it.read_row][it.read_col];
            end
            MODE_CLEAR:
            begin
                blank_screen_model();
                cur_r = 0;
                cur_c = 0;
            end
            default: ;
        endcase
        r.cursor_row = 5'(cur_r);
        r.cursor_col = 6'(cur_c);
        r.scrolled   = rolled;
        return r;
    endfunction

    // Drive one transaction, wait for acceptance, record its expected result
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                             input logic [4:0] row, input logic [5:0] col);
        item_t             it;
        logic [CHAR_W-1:0] code;
        it.mode     = mode;
        it.char_in  = ch;
        it.read_row = row;
        it.read_col = col;
        code        = ch[CHAR_W-1:0];
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(predict_screen(it));
        items_sent++;
        if (!(mode == MODE_UNUSED ||
              (mode == MODE_WRITE && code < CODE_SPACE && code != CODE_CR && code != CODE_BS)))
            useful_items++;
        if (mode == MODE_READ)
            reads_sent++;
        if (mode == MODE_CLEAR)
            clears_sent++;
        // Drop start for a random burst now and then
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (result.scrolled)
                scrolls_seen++;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: result with no transaction pending: row %0d col %0d",
                             result.cursor_row, result.cursor_col);
            end
            else
            begin
                want_res = expected_q.pop_front();
                if (result.cursor_row !== want_res.cursor_row ||
                    result.cursor_col !== want_res.cursor_col ||
                    result.scrolled   !== want_res.scrolled ||
                    result.read_char  !== want_res.read_char)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"ERROR: result %0d: row %0d/%0d col %0d/%0d ",
                                  "scrolled %0b/%0b char %h/%h (expected/actual)"},
                                 results_seen,
                                 want_res.cursor_row, result.cursor_row,
                                 want_res.cursor_col, result.cursor_col,
                                 want_res.scrolled, result.scrolled,
                                 want_res.read_char, result.read_char);
                end
            end
        end
    end

    // Blank screen after reset: reads, and an unused mode with every bit set
    task automatic test_power_up_state();
        send_item(MODE_READ, 8'h00, 5'd0, 6'd0);
        send_item(MODE_READ, 8'h00, 5'(LINES - 1), 6'(COLS - 1));
        send_item(MODE_UNUSED, 8'hFF, 5'h1F, 6'h3F);
    endtask

    // Printable codes: case folding, range ends, ignored top bit
    task automatic test_printable_codes();
        send_item(MODE_WRITE, 8'h61, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h7A, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h7E, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'hC1, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h20, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h60, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h7B, 5'd0, 6'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 6'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 6'd1);
    endtask

    // Rubout family, carriage return, backspace at column zero, other controls
    task automatic test_editing_codes();
        send_item(MODE_WRITE, 8'h08, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'hFF, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h5F, 5'd0, 6'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 6'd4);
        send_item(MODE_WRITE, 8'h8D, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h08, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h00, 5'd0, 6'd0);
        send_item(MODE_WRITE, 8'h1F, 5'd0, 6'd0);
    endtask

    // Reads just past and just inside the screen edges
    task automatic test_read_bounds();
        send_item(MODE_READ, 8'h00, 5'(LINES), 6'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 6'(COLS));
        send_item(MODE_READ, 8'h00, 5'(LINES - 1), 6'(COLS - 1));
    endtask

    // Clear homes the cursor and blanks the screen
    task automatic test_clear_screen();
        send_item(MODE_CLEAR, 8'h41, 5'd3, 6'd3);
        send_item(MODE_READ, 8'h00, 5'd0, 6'd0);
    endtask

    // Random text lines, edits, reads, carriage return runs, clears and noise
    task automatic test_random_text();
        int         kind;
        int         len;
        logic [7:0] ch;
        logic [4:0] row;
        logic [5:0] col;
        while (useful_items < RANDOM_ITEMS)
        begin
            kind    = $urandom_range(0, 99);
            gaps_on = (useful_items < RANDOM_ITEMS - GAP_FREE_TAIL) && ($urandom_range(0, 2) != 0);
            if (kind < 55)
            begin
                // Line of text, usually ended by a carriage return
                len = $urandom_range(0, 50);
                for (int i = 0; i < len; i++)
                begin
                    ch = 8'($urandom_range(32'h20, 32'h7E));
                    if ($urandom_range(0, 7) == 0)
                        ch[7] = 1'b1;
                    send_item(MODE_WRITE, ch, 5'($urandom), 6'($urandom));
                end
                if ($urandom_range(0, 3) != 0)
                    send_item(MODE_WRITE, {1'($urandom), CODE_CR}, 5'd0, 6'd0);
            end
            else if (kind < 70)
            begin
                // Reads, often of the current line
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            row = 5'($urandom);
                            col = 6'($urandom);
                        end
                        1, 2:
                        begin
                            row = 5'(cur_r);
                            col = 6'($urandom_range(0, COLS - 1));
                        end
                        default:
                        begin
                            row = 5'($urandom_range(0, LINES - 1));
                            col = 6'($urandom_range(0, COLS - 1));
                        end
                    endcase
                    send_item(MODE_READ, 8'($urandom), row, col);
                end
            end
            else if (kind < 80)
            begin
                // Run of rubout-type codes
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 2))
                        0:       ch = {1'b0, CODE_BS};
                        1:       ch = {1'b0, CODE_RUBOUT};
                        default: ch = {1'b0, CODE_UNDERSCORE};
                    endcase
                    ch[7] = 1'($urandom);
                    send_item(MODE_WRITE, ch, 5'($urandom), 6'($urandom));
                end
            end
            else if (kind < 85)
            begin
                // Carriage return run, which may reach the bottom and scroll
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    send_item(MODE_WRITE, {1'($urandom), CODE_CR}, 5'd0, 6'd0);
            end
            else if (kind < 87)
                send_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 6'($urandom));
            else
            begin
                // Noise: any field value in any mode
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_item(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
            end
        end
    endtask

    initial
    begin
        blank_screen_model();
        cur_r = 0;
        cur_c = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_state();
        test_printable_codes();
        test_editing_codes();
        test_read_bounds();
        test_clear_screen();
        test_random_text();

        // Drain outstanding results, then let the block settle
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d reads, %0d clears), checked %0d results",
                 items_sent, reads_sent, clears_sent, results_seen);
        $display("Screen scrolled %0d times; %0d mismatches", scrolls_seen, mismatch_count);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #25_000_000;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

### terminal_screen_char_writer.f
sv/tscw_pkg.sv
sv/tscw_screen_ram.sv
sv/terminal_screen_char_writer.sv
bench/terminal_screen_char_writer_tb.sv
